// ----- rtl/core/sfr_pkg.sv -----
// Shared constants, codes and types of the serial frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int HDR_BYTES   = 5;
    localparam int POS_W       = $clog2(HDR_BYTES + MAX_PAYLOAD + 1);
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHECK_BASE     = 8'hFC;
    localparam logic [7:0] SYNC_RESET     = 8'hFC;
    localparam logic [7:0] PRE1_RESET     = 8'h04;
    localparam logic [7:0] PRE2_RESET     = 8'h03;
    localparam logic [7:0] MAX_LEN_BYTE   = 8'(MAX_PAYLOAD);

    localparam logic [7:0] TYPE_REQ_LO    = 8'h48;
    localparam logic [7:0] TYPE_REQ_HI    = 8'h4C;
    localparam logic [7:0] TYPE_RSP_LO    = 8'h68;
    localparam logic [7:0] TYPE_RSP_HI    = 8'h6C;
    localparam logic [7:0] TYPE_CONNECT   = 8'h5A;
    localparam logic [7:0] TYPE_CONN_RSP  = 8'h7A;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE2 = 2'd2;

    localparam logic [POS_W-1:0] POS_HUNT = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PRE1 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_PRE2 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(HDR_BYTES);

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TYPE     = 3'd1,
        ERR_PREAMBLE = 3'd2,
        ERR_LENGTH   = 3'd3,
        ERR_CHECKSUM = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] data;
        logic       sync_hit;
        logic       type_known;
        logic       type_reply;
        logic       type_connect;
        logic       pre1_hit;
        logic       pre2_hit;
        logic       oversize;
    } t_item;

endpackage

// ----- rtl/core/sfr_front.sv -----
// Front end: configuration registers and per-byte classification.
`timescale 1ns / 1ps
module sfr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_push_valid,
    output sfr_pkg::t_item                 o_push_item,
    input  logic                           i_push_ready
);
    import sfr_pkg::*;

    logic [7:0] r_sync;
    logic [7:0] r_pre1;
    logic [7:0] r_pre2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_pre1 <= PRE1_RESET;
            r_pre2 <= PRE2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC: r_sync <= i_cfg_data;
                CFG_PRE1: r_pre1 <= i_cfg_data;
                CFG_PRE2: r_pre2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic is_req;
    logic is_rsp;

    always_comb begin
        is_req = (i_rx_byte >= TYPE_REQ_LO) && (i_rx_byte <= TYPE_REQ_HI);
        is_rsp = (i_rx_byte >= TYPE_RSP_LO) && (i_rx_byte <= TYPE_RSP_HI);
        o_push_item.data         = i_rx_byte;
        o_push_item.sync_hit     = (i_rx_byte == r_sync);
        o_push_item.type_known   = is_req || is_rsp || (i_rx_byte == TYPE_CONNECT)
                                   || (i_rx_byte == TYPE_CONN_RSP);
        o_push_item.type_reply   = is_req;
        o_push_item.type_connect = (i_rx_byte == TYPE_CONNECT);
        o_push_item.pre1_hit     = (i_rx_byte == r_pre1);
        o_push_item.pre2_hit     = (i_rx_byte == r_pre2);
        o_push_item.oversize     = (i_rx_byte > MAX_LEN_BYTE);
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

// ----- rtl/core/sfr_queue.sv -----
// Two-entry item queue between the classifier and the frame parser.
`timescale 1ns / 1ps
module sfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  sfr_pkg::t_item  i_push_item,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output sfr_pkg::t_item  o_pop_item,
    input  logic            i_pop_ready
);
    import sfr_pkg::*;

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) && !push |=> (r_count == '0))
        else $error("queue count moved without a push");

    a_full_then_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CW'(Q_DEPTH)) && pop |=> (r_count == Q_CW'(Q_DEPTH - 1)))
        else $error("full queue miscounted on pop");

endmodule

// ----- rtl/core/sfr_back.sv -----
// Back end: frame position tracking, checksum and the registered result.
`timescale 1ns / 1ps
module sfr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_pop_valid,
    input  sfr_pkg::t_item               i_pop_item,
    output logic                         o_pop_ready,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic                         o_payload_valid,
    output logic [sfr_pkg::IDX_W-1:0]    o_payload_index,
    output logic [7:0]                   o_payload_byte,
    output logic                         o_frame_done,
    output logic [2:0]                   o_frame_error,
    output logic [7:0]                   o_packet_type,
    output logic [sfr_pkg::LEN_W-1:0]    o_payload_length,
    output logic                         o_reply_request,
    output logic                         o_connect_request,
    output logic [7:0]                   o_active_message
);
    import sfr_pkg::*;

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [7:0]       r_sum,   n_sum;
    logic [7:0]       r_type,  n_type;
    logic             r_treq,  n_treq;
    logic             r_tconn, n_tconn;
    logic [7:0]       r_msg,   n_msg;

    logic             r_res_valid;
    logic             r_pv,    n_pv;
    logic [IDX_W-1:0] r_idx,   n_idx;
    logic [7:0]       r_pbyte, n_pbyte;
    logic             r_done,  n_done;
    t_err             r_err,   n_err;
    logic             r_reply, n_reply;
    logic             r_conn,  n_conn;

    logic             pop;
    logic [POS_W-1:0] last;
    logic [7:0]       c;

    assign o_pop_ready = !r_res_valid || i_res_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign last        = POS_DATA + POS_W'(r_len);
    assign c           = i_pop_item.data;

    always_comb begin
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_type  = r_type;
        n_treq  = r_treq;
        n_tconn = r_tconn;
        n_msg   = r_msg;
        n_pv    = 1'b0;
        n_idx   = '0;
        n_pbyte = '0;
        n_done  = 1'b0;
        n_err   = ERR_NONE;
        n_reply = 1'b0;
        n_conn  = 1'b0;
        if (r_pos == POS_HUNT) begin
            if (i_pop_item.sync_hit) begin
                n_sum = c;
                n_pos = POS_TYPE;
            end
        end else if (r_pos == POS_TYPE) begin
            if (i_pop_item.type_known) begin
                n_type  = c;
                n_treq  = i_pop_item.type_reply;
                n_tconn = i_pop_item.type_connect;
                n_sum   = r_sum + c;
                n_pos   = POS_PRE1;
            end else begin
                n_err = ERR_TYPE;
                n_pos = POS_HUNT;
            end
        end else if (r_pos == POS_PRE1 || r_pos == POS_PRE2) begin
            if ((r_pos == POS_PRE1) ? i_pop_item.pre1_hit : i_pop_item.pre2_hit) begin
                n_sum = r_sum + c;
                n_pos = r_pos + 1'b1;
            end else begin
                n_err = ERR_PREAMBLE;
                n_pos = POS_HUNT;
            end
        end else if (r_pos == POS_LEN) begin
            if (i_pop_item.oversize) begin
                n_err = ERR_LENGTH;
                n_pos = POS_HUNT;
            end else begin
                n_len = c[LEN_W-1:0];
                n_sum = r_sum + c;
                n_pos = POS_DATA;
            end
        end else if (r_pos < last) begin
            n_pv    = 1'b1;
            n_idx   = IDX_W'(r_pos - POS_DATA);
            n_pbyte = c;
            n_sum   = r_sum + c;
            n_pos   = r_pos + 1'b1;
        end else begin
            n_pos = POS_HUNT;
            if (c == CHECK_BASE - r_sum) begin
                n_done = 1'b1;
                if (r_treq) begin
                    n_reply = 1'b1;
                    n_msg   = r_type;
                end else if (r_tconn) begin
                    n_conn = 1'b1;
                end
            end else begin
                n_err = ERR_CHECKSUM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_len       <= '0;
            r_sum       <= '0;
            r_type      <= '0;
            r_treq      <= 1'b0;
            r_tconn     <= 1'b0;
            r_msg       <= '0;
            r_res_valid <= 1'b0;
        end else if (pop) begin
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_type      <= n_type;
            r_treq      <= n_treq;
            r_tconn     <= n_tconn;
            r_msg       <= n_msg;
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_pv    <= n_pv;
            r_idx   <= n_idx;
            r_pbyte <= n_pbyte;
            r_done  <= n_done;
            r_err   <= n_err;
            r_reply <= n_reply;
            r_conn  <= n_conn;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_payload_valid   = r_pv;
    assign o_payload_index   = r_idx;
    assign o_payload_byte    = r_pbyte;
    assign o_frame_done      = r_done;
    assign o_frame_error     = r_err;
    assign o_packet_type     = r_type;
    assign o_payload_length  = r_len;
    assign o_reply_request   = r_reply;
    assign o_connect_request = r_conn;
    assign o_active_message  = r_msg;

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= last)
        else $error("frame position past checksum byte");

    a_done_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_done |-> (r_err == ERR_NONE) && !r_pv)
        else $error("frame done with error or payload flag");

    a_reply_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_reply |-> r_done && (r_msg == r_type) && !r_conn)
        else $error("reply request without latched message");

    a_error_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (n_err != ERR_NONE) |=> (r_pos == POS_HUNT))
        else $error("parser did not return to hunting after error");

endmodule

// ----- rtl/core/serial_frame_receiver_checksum_unit.sv -----
// Top level of the serial frame receiver with additive checksum.
//
// Input channel: one received byte per item on i_rx_byte (i_in_valid / o_in_ready).
// Output channel: one result item per input item (o_res_valid / i_res_ready),
// carrying payload flag, index and byte, frame done, error code, packet type,
// declared length, reply and connect pulses and the latched message code.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 sync byte, 1 first preamble byte, 2 second preamble byte); write only
// while no item is in flight. Other indexes are ignored.
// An accepted byte is registered in the queue, then in the result register.
// Throughput: one item per cycle while i_res_ready is high, set by the parser's
// position/checksum update. A two-entry queue separates classification from
// parsing; a new item enters the parser once the previous result is accepted.
// Reset clears the parser to sync hunting, restores the register defaults and
// empties the queue. When the receiver stalls, the result is held, the queue
// fills, and o_in_ready drops once two items are waiting.
`timescale 1ns / 1ps
module serial_frame_receiver_checksum_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic                           o_payload_valid,
    output logic [3:0]                     o_payload_index,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_frame_done,
    output logic [2:0]                     o_frame_error,
    output logic [7:0]                     o_packet_type,
    output logic [4:0]                     o_payload_length,
    output logic                           o_reply_request,
    output logic                           o_connect_request,
    output logic [7:0]                     o_active_message
);
    import sfr_pkg::*;

    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    sfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    sfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    sfr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pop_valid       (pop_valid),
        .i_pop_item        (pop_item),
        .o_pop_ready       (pop_ready),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_payload_valid   (o_payload_valid),
        .o_payload_index   (o_payload_index),
        .o_payload_byte    (o_payload_byte),
        .o_frame_done      (o_frame_done),
        .o_frame_error     (o_frame_error),
        .o_packet_type     (o_packet_type),
        .o_payload_length  (o_payload_length),
        .o_reply_request   (o_reply_request),
        .o_connect_request (o_connect_request),
        .o_active_message  (o_active_message)
    );

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the serial frame receiver with additive checksum.
`timescale 1ns / 1ps

typedef struct packed {
    logic       pv;
    logic [3:0] idx;
    logic [7:0] data;
    logic       done;
    logic [2:0] err;
    logic [7:0] ptype;
    logic [4:0] plen;
    logic       reply;
    logic       conn;
    logic [7:0] active;
} frame_result_t;

class frame_checker;
    logic [7:0]    sync_byte;
    logic [7:0]    pre1_byte;
    logic [7:0]    pre2_byte;
    int unsigned   position;
    logic [4:0]    length_q;
    logic [7:0]    sum_q;
    logic [7:0]    type_q;
    logic [7:0]    message_q;
    frame_result_t expected_results[$];
    int unsigned   error_count;

    function new();
        sync_byte   = sfr_pkg::SYNC_RESET;
        pre1_byte   = sfr_pkg::PRE1_RESET;
        pre2_byte   = sfr_pkg::PRE2_RESET;
        position    = sfr_pkg::POS_HUNT;
        length_q    = '0;
        sum_q       = '0;
        type_q      = '0;
        message_q   = '0;
        error_count = 0;
    endfunction

    function void set_reg(logic [sfr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            sfr_pkg::CFG_SYNC: sync_byte = value;
            sfr_pkg::CFG_PRE1: pre1_byte = value;
            sfr_pkg::CFG_PRE2: pre2_byte = value;
            default: ;
        endcase
    endfunction

    function bit known_code(logic [7:0] t);
        return (t >= sfr_pkg::TYPE_REQ_LO && t <= sfr_pkg::TYPE_REQ_HI) ||
               (t >= sfr_pkg::TYPE_RSP_LO && t <= sfr_pkg::TYPE_RSP_HI) ||
               t == sfr_pkg::TYPE_CONNECT || t == sfr_pkg::TYPE_CONN_RSP;
    endfunction

    function void note_byte(logic [7:0] c);
        frame_result_t r;
        int unsigned   last;
        r    = '0;
        last = sfr_pkg::HDR_BYTES + length_q;
        if (position == sfr_pkg::POS_HUNT) begin
            if (c == sync_byte) begin
                sum_q    = c;
                position = sfr_pkg::POS_TYPE;
            end
        end else if (position == sfr_pkg::POS_TYPE) begin
            if (known_code(c)) begin
                type_q   = c;
                sum_q    = sum_q + c;
                position = sfr_pkg::POS_PRE1;
            end else begin
                r.err    = sfr_pkg::ERR_TYPE;
                position = sfr_pkg::POS_HUNT;
            end
        end else if (position == sfr_pkg::POS_PRE1 || position == sfr_pkg::POS_PRE2) begin
            if (c == ((position == sfr_pkg::POS_PRE1) ? pre1_byte : pre2_byte)) begin
                sum_q    = sum_q + c;
                position = position + 1;
            end else begin
                r.err    = sfr_pkg::ERR_PREAMBLE;
                position = sfr_pkg::POS_HUNT;
            end
        end else if (position == sfr_pkg::POS_LEN) begin
            if (c > sfr_pkg::MAX_LEN_BYTE) begin
                r.err    = sfr_pkg::ERR_LENGTH;
                position = sfr_pkg::POS_HUNT;
            end else begin
                length_q = c[4:0];
                sum_q    = sum_q + c;
                position = sfr_pkg::POS_DATA;
            end
        end else if (position < last) begin
            r.pv     = 1'b1;
            r.idx    = 4'(position - sfr_pkg::HDR_BYTES);
            r.data   = c;
            sum_q    = sum_q + c;
            position = position + 1;
        end else begin
            position = sfr_pkg::POS_HUNT;
            if (c == 8'(sfr_pkg::CHECK_BASE - sum_q)) begin
                r.done = 1'b1;
                if (type_q >= sfr_pkg::TYPE_REQ_LO && type_q <= sfr_pkg::TYPE_REQ_HI) begin
                    r.reply   = 1'b1;
                    message_q = type_q;
                end else if (type_q == sfr_pkg::TYPE_CONNECT) begin
                    r.conn = 1'b1;
                end
            end else begin
                r.err = sfr_pkg::ERR_CHECKSUM;
            end
        end
        r.ptype  = type_q;
        r.plen   = length_q;
        r.active = message_q;
        expected_results.push_back(r);
    endfunction

    function string show(frame_result_t r);
        return $sformatf("pv=%0d idx=%0d byte=%02h done=%0d err=%0d type=%02h len=%0d rep=%0d con=%0d msg=%02h",
                         r.pv, r.idx, r.data, r.done, r.err, r.ptype, r.plen,
                         r.reply, r.conn, r.active);
    endfunction

    function void check_result(frame_result_t got);
        frame_result_t want;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("%0t unexpected result: %s", $realtime, show(got));
            return;
        end
        want = expected_results.pop_front();
        if (want.pv !== got.pv || want.idx !== got.idx || want.data !== got.data ||
            want.done !== got.done || want.err !== got.err || want.ptype !== got.ptype ||
            want.plen !== got.plen || want.reply !== got.reply || want.conn !== got.conn ||
            want.active !== got.active) begin
            error_count++;
            if (error_count <= 10) begin
                $display("%0t mismatch expected: %s", $realtime, show(want));
                $display("%0t mismatch actual:   %s", $realtime, show(got));
            end
        end
    endfunction
endclass

module tb;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 220;
    localparam int unsigned HOLD_CYCLES    = 6;
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_PRE1,
        FLAW_PRE2,
        FLAW_CHECKSUM,
        FLAW_CUT
    } frame_flaw_t;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                    i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic [7:0]                    i_rx_byte   = '0;
    logic                          o_res_valid;
    logic                          i_res_ready = 1'b0;
    logic                          o_payload_valid;
    logic [3:0]                    o_payload_index;
    logic [7:0]                    o_payload_byte;
    logic                          o_frame_done;
    logic [2:0]                    o_frame_error;
    logic [7:0]                    o_packet_type;
    logic [4:0]                    o_payload_length;
    logic                          o_reply_request;
    logic                          o_connect_request;
    logic [7:0]                    o_active_message;

    frame_result_t seen_result;
    frame_checker  sb;
    logic [7:0]    cfg_sync = sfr_pkg::SYNC_RESET;
    logic [7:0]    cfg_pre1 = sfr_pkg::PRE1_RESET;
    logic [7:0]    cfg_pre2 = sfr_pkg::PRE2_RESET;
    int unsigned   burst_left  = 0;
    int unsigned   item_count  = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   ready_mode  = 0;
    int unsigned   mode_left   = 0;
    int unsigned   tick        = 0;

    assign seen_result = {o_payload_valid, o_payload_index, o_payload_byte, o_frame_done,
                          o_frame_error, o_packet_type, o_payload_length, o_reply_request,
                          o_connect_request, o_active_message};

    serial_frame_receiver_checksum_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_payload_valid  (o_payload_valid),
        .o_payload_index  (o_payload_index),
        .o_payload_byte   (o_payload_byte),
        .o_frame_done     (o_frame_done),
        .o_frame_error    (o_frame_error),
        .o_packet_type    (o_packet_type),
        .o_payload_length (o_payload_length),
        .o_reply_request  (o_reply_request),
        .o_connect_request(o_connect_request),
        .o_active_message (o_active_message)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_byte(i_rx_byte);
            if (o_res_valid && i_res_ready)
                sb.check_result(seen_result);
        end
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_res_valid && i_res_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        tick <= tick + 1;
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(3, 0);
            mode_left  <= $urandom_range(256, 64);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: i_res_ready <= 1'b1;
            1: i_res_ready <= ($urandom_range(3, 0) != 0);
            2: i_res_ready <= ((tick % 11) >= 6);
            default: i_res_ready <= $urandom_range(1, 0);
        endcase
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL serial_frame_receiver_checksum_unit");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 40)
                                                     : $urandom_range(12, 1);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold the sender until every expected result has come, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
        repeat (HOLD_CYCLES) @(posedge i_clk);
        burst_left = $urandom_range(30, 1);
    endtask

    task automatic put_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] s, input logic [7:0] p1, input logic [7:0] p2);
        drain();
        put_reg(sfr_pkg::CFG_SYNC, s);
        put_reg(sfr_pkg::CFG_PRE1, p1);
        put_reg(sfr_pkg::CFG_PRE2, p2);
        put_reg(CFG_UNUSED, 8'($urandom_range(255, 0)));
        i_cfg_we <= 1'b0;
        cfg_sync = s;
        cfg_pre1 = p1;
        cfg_pre2 = p2;
    endtask

    // build one frame; header faults end the frame at the offending byte
    task automatic send_frame(input logic [7:0] kind, input logic [7:0] len_byte,
                              input frame_flaw_t flaw);
        logic [7:0]  bytes[$];
        logic [7:0]  sum;
        logic [7:0]  mask;
        int unsigned keep;
        bytes = {};
        mask  = 8'($urandom_range(255, 1));
        bytes.push_back(cfg_sync);
        bytes.push_back(kind);
        if (sb.known_code(kind)) begin
            bytes.push_back((flaw == FLAW_PRE1) ? (cfg_pre1 ^ mask) : cfg_pre1);
            if (flaw != FLAW_PRE1) begin
                bytes.push_back((flaw == FLAW_PRE2) ? (cfg_pre2 ^ mask) : cfg_pre2);
                if (flaw != FLAW_PRE2) begin
                    bytes.push_back(len_byte);
                    if (len_byte <= sfr_pkg::MAX_LEN_BYTE) begin
                        repeat (len_byte) bytes.push_back(8'($urandom_range(255, 0)));
                        sum = '0;
                        foreach (bytes[k]) sum = sum + bytes[k];
                        sum = sfr_pkg::CHECK_BASE - sum;
                        bytes.push_back((flaw == FLAW_CHECKSUM) ? (sum ^ mask) : sum);
                    end
                end
            end
        end
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(bytes.size() - 1, 1);
            while (bytes.size() > keep) void'(bytes.pop_back());
        end
        foreach (bytes[k]) begin
            send_byte(bytes[k]);
            item_count++;
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  kind;
        logic [7:0]  len_byte;
        frame_flaw_t flaw;
        int unsigned pick;
        pick = $urandom_range(11, 0);
        if (pick < 5)
            kind = sfr_pkg::TYPE_REQ_LO + 8'(pick);
        else if (pick < 10)
            kind = sfr_pkg::TYPE_RSP_LO + 8'(pick - 5);
        else
            kind = (pick == 10) ? sfr_pkg::TYPE_CONNECT : sfr_pkg::TYPE_CONN_RSP;
        len_byte = ($urandom_range(9, 0) == 0) ? sfr_pkg::MAX_LEN_BYTE
                                               : 8'($urandom_range(sfr_pkg::MAX_PAYLOAD, 0));
        flaw = FLAW_NONE;
        pick = $urandom_range(99, 0);
        if (pick < 65) begin
            flaw = FLAW_NONE;
        end else if (pick < 72) begin
            do kind = 8'($urandom_range(255, 0)); while (sb.known_code(kind));
        end else if (pick < 77) begin
            flaw = FLAW_PRE1;
        end else if (pick < 82) begin
            flaw = FLAW_PRE2;
        end else if (pick < 87) begin
            len_byte = 8'($urandom_range(255, sfr_pkg::MAX_PAYLOAD + 1));
        end else if (pick < 93) begin
            flaw = FLAW_CHECKSUM;
        end else begin
            flaw = FLAW_CUT;
        end
        if ($urandom_range(7, 0) == 0)
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
        send_frame(kind, len_byte, flaw);
    endtask

    initial begin
        int unsigned phase_end;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(~sfr_pkg::SYNC_RESET);
        send_frame(sfr_pkg::TYPE_REQ_LO, 8'd0, FLAW_NONE);
        send_frame(sfr_pkg::TYPE_CONNECT, 8'd1, FLAW_NONE);
        send_frame(sfr_pkg::TYPE_CONNECT, 8'd0, FLAW_CHECKSUM);
        send_frame(8'h00, 8'd0, FLAW_NONE);
        send_frame(sfr_pkg::TYPE_RSP_HI, 8'd0, FLAW_PRE1);
        send_frame(sfr_pkg::TYPE_CONN_RSP, 8'hFF, FLAW_NONE);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: write_regs(sfr_pkg::SYNC_RESET, sfr_pkg::PRE1_RESET, sfr_pkg::PRE2_RESET);
                1: write_regs(8'h00, 8'h00, 8'h00);
                2: write_regs(8'hFF, 8'hFF, 8'hFF);
                default: write_regs(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                    8'($urandom_range(255, 0)));
            endcase
            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end) begin
                send_random_frame();
                if (phase == 3 && item_count >= phase_end - PHASE_ITEMS / 2
                    && item_count < phase_end - PHASE_ITEMS / 2 + 20)
                    drain();
            end
        end

        drain();
        if (sb.expected_results.size() != 0)
            $display("results missing: %0d", sb.expected_results.size());
        if (sb.error_count == 0 && sb.expected_results.size() == 0)
            $display("PASS serial_frame_receiver_checksum_unit");
        else
            $display("FAIL serial_frame_receiver_checksum_unit");
        $finish;
    end
endmodule
